// ----- rtl/conv3_pkg.sv -----
// conv3_pkg: shared types, constants and helpers of the 3x3 convolution filter
// used by conv3_ctrl, conv3_datapath and conv3x3_zero_padded_filter_unit
// depends on nothing else
package conv3_pkg;

   // fixed field widths
   localparam int PIX_BITS   = 8;
   localparam int GEOM_BITS  = 11;
   localparam int SCALE_BITS = 17;
   localparam int FRAC_BITS  = 16;
   localparam int WORD_BITS  = 64;
   localparam int TAPS       = 9;
   localparam int TAP_COLS   = 3;
   localparam int ROW_BITS   = 2;
   localparam int CSR_ADDR_BITS = 2;

   localparam logic [PIX_BITS-1:0]   PIX_MAX      = 8'hFF;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET  = 17'd7281;
   localparam logic [GEOM_BITS-1:0]  GEOM_RESET   = 11'd10;
   localparam int                    MIN_WIDTH    = 3;
   localparam int                    MIN_HEIGHT   = 1;

   // window row being accumulated
   localparam logic [ROW_BITS-1:0] ROW_TOP = 2'd0;
   localparam logic [ROW_BITS-1:0] ROW_MID = 2'd1;
   localparam logic [ROW_BITS-1:0] ROW_BOT = 2'd2;

   // register indexes of the configuration port
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_KERNEL = 2'd0,
      REG_SCALE  = 2'd1,
      REG_WIDTH  = 2'd2,
      REG_HEIGHT = 2'd3
   } csr_index_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic                accept;
      logic                shift;
      logic                mac;
      logic                mac_first;
      logic [ROW_BITS-1:0] mac_row;
      logic                scale;
      logic                load_out;
   } conv3_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic emit;
      logic out_free;
   } conv3_status_type;

   // clamp a geometry register value into lo..hi
   function automatic int clamp_geom(input logic [GEOM_BITS-1:0] v, input int lo,
                                     input int hi);
      int x;
      begin
         x = int'(v);
         if (x < lo) x = lo;
         if (x > hi) x = hi;
         return x;
      end
   endfunction

endpackage

// ----- rtl/conv3x3_zero_padded_filter_unit.sv -----
// conv3x3_zero_padded_filter_unit: top level of the streaming 3x3 convolution filter
// instantiates conv3_ctrl and conv3_datapath; depends on conv3_pkg
//
// channel  direction  payload
// req_     in         tdata[7:0] pixel_in, tuser is_fill
// rsp_     out        tdata[7:0] pixel_out, tuser was_clamped, tlast end_of_frame
// csr_     in         wen, addr (register index), data (widest register)
//
// an item that gives no result passes through accept and the window and line store update
// an item with a result passes through accept, update, three row steps of the MAC, scale, load
// a full result register holds the load step until rsp_tready frees it, and the next item
// is not taken while it waits
// synchronous reset clears counters and handshakes and loads configuration defaults; line
// stores hold whatever they held and need no clearing pass
module conv3x3_zero_padded_filter_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COEF_BITS  = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [conv3_pkg::PIX_BITS-1:0]       req_tdata,   // [7:0] pixel_in
   input  logic                                 req_tuser,   // [0] is_fill
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [conv3_pkg::PIX_BITS-1:0]       rsp_tdata,   // [7:0] pixel_out
   output logic                                 rsp_tuser,   // [0] was_clamped
   output logic                                 rsp_tlast,
   input  logic                                 csr_wen,
   input  logic [conv3_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [conv3_pkg::TAPS*COEF_BITS-1:0] csr_data
);

   conv3_pkg::conv3_cmd_type    cmd;
   conv3_pkg::conv3_status_type status;

   // sequencing
   conv3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // storage and arithmetic
   conv3_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COEF_BITS  (COEF_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/conv3_ctrl.sv -----
// conv3_ctrl: sequencing state machine of the 3x3 convolution filter
// drives conv3_datapath through conv3_pkg command and status structs
// depends on conv3_pkg
module conv3_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  conv3_pkg::conv3_status_type status,
   output conv3_pkg::conv3_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SHIFT = 5'b00010,
      ST_MAC   = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type                           state_ff, state_in;
   logic [conv3_pkg::ROW_BITS-1:0]      mac_row_ff, mac_row_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      mac_row_in    = mac_row_ff;
      cmd           = '0;
      cmd.mac_row   = mac_row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift  = 1'b1;
            mac_row_in = conv3_pkg::ROW_TOP;
            state_in   = status.emit ? ST_MAC : ST_IDLE;
         end
         ST_MAC: begin
            cmd.mac       = 1'b1;
            cmd.mac_first = (mac_row_ff == conv3_pkg::ROW_TOP);
            if (mac_row_ff == conv3_pkg::ROW_BOT) begin
               state_in = ST_SCALE;
            end else begin
               mac_row_in = mac_row_ff + conv3_pkg::ROW_BITS'(1);
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mac_row_ff <= conv3_pkg::ROW_TOP;
      end else begin
         state_ff   <= state_in;
         mac_row_ff <= mac_row_in;
      end
   end

   // an accepted item always goes to the window update next
   a_accept_shift: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_SHIFT)
      else $error("accepted item did not move to shift");

   // three row steps then scaling
   a_mac_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && mac_row_ff == conv3_pkg::ROW_BOT) |=> state_ff == ST_SCALE)
      else $error("accumulation did not end after the bottom row");

   // an item without a result frees the input at once
   a_no_emit_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift && !status.emit) |=> req_tready)
      else $error("input not ready after item without result");

endmodule

// ----- rtl/conv3_datapath.sv -----
// conv3_datapath: line stores, 3x3 window, position counters, row-wise MAC,
// scaling, clamping and result register of the 3x3 convolution filter
// depends on conv3_pkg; commanded by conv3_ctrl
module conv3_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int COEF_BITS  = 5
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [conv3_pkg::PIX_BITS-1:0]           req_tdata,
   input  logic                                     req_tuser,
   input  logic                                     csr_wen,
   input  logic [conv3_pkg::CSR_ADDR_BITS-1:0]      csr_addr,
   input  logic [conv3_pkg::TAPS*COEF_BITS-1:0]     csr_data,
   input  conv3_pkg::conv3_cmd_type                 cmd,
   output conv3_pkg::conv3_status_type              status,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [conv3_pkg::PIX_BITS-1:0]           rsp_tdata,
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);

   localparam int KW_W   = conv3_pkg::TAPS * COEF_BITS;
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int RW     = $clog2(MAX_HEIGHT + 2);
   localparam int PROD_W = COEF_BITS + conv3_pkg::PIX_BITS + 1;
   localparam int SUM_W  = PROD_W + 4;
   localparam int P_W    = SUM_W + conv3_pkg::SCALE_BITS + 1;
   localparam int QW     = P_W - conv3_pkg::FRAC_BITS;
   localparam int PB     = conv3_pkg::PIX_BITS;

   // coefficient field with value one in each tap
   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1);
   localparam logic [KW_W-1:0] KERNEL_RESET = {conv3_pkg::TAPS{COEF_ONE}};

   // configuration registers
   logic [KW_W-1:0]                  kernel_ff, kernel_in;
   logic [conv3_pkg::SCALE_BITS-1:0] scale_ff, scale_in;
   logic [WW-1:0]                    w_ff, w_in;
   logic [HW-1:0]                    h_ff, h_in;

   // position counters
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] ocol_ff, ocol_in;
   logic [HW-1:0] orow_ff, orow_in;

   // payload
   logic [PB-1:0]           px_ff, px_in;
   logic [PB-1:0]           win_ff [conv3_pkg::TAPS];
   logic [PB-1:0]           win_in [conv3_pkg::TAPS];
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic signed [P_W-1:0]   prod_ff, prod_in;
   logic [PB-1:0]           out_pix_ff, out_pix_in;
   logic                    out_clamp_ff, out_clamp_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_valid_ff, out_valid_in;

   // line stores
   logic [PB-1:0] upper_mem  [MAX_WIDTH];
   logic [PB-1:0] middle_mem [MAX_WIDTH];
   logic [PB-1:0] upper_rd_ff;
   logic [PB-1:0] middle_rd_ff;

   logic                           col_last, ocol_last, orow_last, eof, geom_write;
   logic signed [COEF_BITS-1:0]    coef [conv3_pkg::TAPS];
   logic signed [COEF_BITS-1:0]    coef_sel [conv3_pkg::TAP_COLS];
   logic [PB-1:0]                  pix_sel  [conv3_pkg::TAP_COLS];
   logic                           row_off;
   logic [conv3_pkg::TAP_COLS-1:0] col_off;
   logic signed [PROD_W-1:0]       tap_prod [conv3_pkg::TAP_COLS];
   logic signed [P_W-1:0]          biased;
   logic signed [QW-1:0]           q;

   // position flags
   assign col_last  = (WW'(col_ff) == w_ff - WW'(1));
   assign ocol_last = (WW'(ocol_ff) == w_ff - WW'(1));
   assign orow_last = (orow_ff == h_ff - HW'(1));
   assign eof       = ocol_last && orow_last;
   assign geom_write = csr_wen && (csr_addr == conv3_pkg::REG_WIDTH ||
                                   csr_addr == conv3_pkg::REG_HEIGHT);

   assign status.emit     = (row_ff >= RW'(1) && col_ff != '0) || row_ff >= RW'(2);
   assign status.out_free = !out_valid_ff || rsp_tready;

   // coefficient unpack; taps beyond a 64-bit word read as zero
   always_comb begin
      for (int k = 0; k < conv3_pkg::TAPS; k++) begin
         if (COEF_BITS * k >= conv3_pkg::WORD_BITS) coef[k] = '0;
         else coef[k] = kernel_ff[COEF_BITS*k +: COEF_BITS];
      end
   end

   // window row and border masks for the current accumulation step
   always_comb begin
      for (int c = 0; c < conv3_pkg::TAP_COLS; c++) begin
         case (cmd.mac_row)
            conv3_pkg::ROW_TOP: begin
               pix_sel[c]  = win_ff[c];
               coef_sel[c] = coef[c];
            end
            conv3_pkg::ROW_MID: begin
               pix_sel[c]  = win_ff[c+3];
               coef_sel[c] = coef[c+3];
            end
            default: begin
               pix_sel[c]  = win_ff[c+6];
               coef_sel[c] = coef[c+6];
            end
         endcase
      end
      row_off = (cmd.mac_row == conv3_pkg::ROW_TOP && orow_ff == '0) ||
                (cmd.mac_row == conv3_pkg::ROW_BOT && orow_last);
      col_off = {ocol_last, 1'b0, ocol_ff == '0};
      for (int c = 0; c < conv3_pkg::TAP_COLS; c++) begin
         if (row_off || col_off[c]) tap_prod[c] = '0;
         else tap_prod[c] = PROD_W'(coef_sel[c]) * PROD_W'($signed({1'b0, pix_sel[c]}));
      end
   end

   // truncate toward zero after scaling
   always_comb begin
      biased = prod_ff + (prod_ff[P_W-1] ? P_W'((1 << conv3_pkg::FRAC_BITS) - 1) : P_W'(0));
      q      = $signed(biased[P_W-1:conv3_pkg::FRAC_BITS]);
   end

   // next values
   always_comb begin
      kernel_in    = kernel_ff;
      scale_in     = scale_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      px_in        = px_ff;
      win_in       = win_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      out_pix_in   = out_pix_ff;
      out_clamp_in = out_clamp_ff;
      out_last_in  = out_last_ff;
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;

      // capture the pixel; fills and drain items count as zero
      if (cmd.accept) begin
         px_in = (req_tuser || row_ff >= RW'(h_ff)) ? '0 : req_tdata;
      end

      // window shift and input position
      if (cmd.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r*3]   = win_ff[r*3+1];
            win_in[r*3+1] = win_ff[r*3+2];
         end
         win_in[2] = upper_rd_ff;
         win_in[5] = middle_rd_ff;
         win_in[8] = px_ff;
         if (col_last) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      // one window row per step
      if (cmd.mac) begin
         acc_in = (cmd.mac_first ? SUM_W'(0) : acc_ff) + SUM_W'(tap_prod[0]) +
                  SUM_W'(tap_prod[1]) + SUM_W'(tap_prod[2]);
      end

      if (cmd.scale) begin
         prod_in = P_W'(acc_ff) * P_W'($signed({1'b0, scale_ff}));
      end

      // clamp into the result register and advance the output position
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_last_in  = eof;
         if (q < 0) begin
            out_pix_in   = '0;
            out_clamp_in = 1'b1;
         end else if (q > $signed(QW'(conv3_pkg::PIX_MAX))) begin
            out_pix_in   = conv3_pkg::PIX_MAX;
            out_clamp_in = 1'b1;
         end else begin
            out_pix_in   = q[PB-1:0];
            out_clamp_in = 1'b0;
         end
         if (eof) begin
            col_in  = '0;
            row_in  = '0;
            ocol_in = '0;
            orow_in = '0;
         end else if (ocol_last) begin
            ocol_in = '0;
            orow_in = orow_ff + HW'(1);
         end else begin
            ocol_in = ocol_ff + CW'(1);
         end
      end

      // configuration writes; geometry restarts the frame
      if (csr_wen) begin
         unique case (csr_addr)
            conv3_pkg::REG_KERNEL: kernel_in = csr_data;
            conv3_pkg::REG_SCALE:  scale_in  = csr_data[conv3_pkg::SCALE_BITS-1:0];
            conv3_pkg::REG_WIDTH:  w_in = WW'(conv3_pkg::clamp_geom(
                                      csr_data[conv3_pkg::GEOM_BITS-1:0],
                                      conv3_pkg::MIN_WIDTH, MAX_WIDTH));
            conv3_pkg::REG_HEIGHT: h_in = HW'(conv3_pkg::clamp_geom(
                                      csr_data[conv3_pkg::GEOM_BITS-1:0],
                                      conv3_pkg::MIN_HEIGHT, MAX_HEIGHT));
            default: ;
         endcase
      end
      if (geom_write) begin
         col_in  = '0;
         row_in  = '0;
         ocol_in = '0;
         orow_in = '0;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff    <= KERNEL_RESET;
         scale_ff     <= conv3_pkg::SCALE_RESET;
         w_ff         <= WW'(conv3_pkg::clamp_geom(conv3_pkg::GEOM_RESET,
                                                   conv3_pkg::MIN_WIDTH, MAX_WIDTH));
         h_ff         <= HW'(conv3_pkg::clamp_geom(conv3_pkg::GEOM_RESET,
                                                   conv3_pkg::MIN_HEIGHT, MAX_HEIGHT));
         col_ff       <= '0;
         row_ff       <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         kernel_ff    <= kernel_in;
         scale_ff     <= scale_in;
         w_ff         <= w_in;
         h_ff         <= h_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      win_ff       <= win_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      out_pix_ff   <= out_pix_in;
      out_clamp_ff <= out_clamp_in;
      out_last_ff  <= out_last_in;
   end

   // line stores: read at the column every cycle, written on window shift
   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         upper_mem[col_ff]  <= middle_rd_ff;
         middle_mem[col_ff] <= px_ff;
      end
      upper_rd_ff  <= upper_mem[col_ff];
      middle_rd_ff <= middle_mem[col_ff];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tuser  = out_clamp_ff;
   assign rsp_tlast  = out_last_ff;

   // input column stays inside the row
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < w_ff)
      else $error("column counter beyond image width");

   // input rows run at most to the frame height plus one while draining
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      RW'(row_ff) <= RW'(h_ff) + RW'(1))
      else $error("row counter beyond drain limit");

   // last result of a frame restarts every counter
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && eof) |=> (col_ff == '0 && row_ff == '0 && ocol_ff == '0 &&
                                 orow_ff == '0 && rsp_tlast))
      else $error("frame end did not restart counters");

endmodule
